/* rtl/gsia_pkg.sv */
// Shared types, constants and codes of the generational slot identifier allocator.
package gsia_pkg;

   // Field widths fixed by the identifier format.
   localparam int ID_W         = 32;
   localparam int KEY_W        = 32;
   localparam int SLOT_FIELD_W = 16;
   localparam int GEN_W        = 16;
   localparam int CFG_W        = 17;

   // Default sizes of the slot stores and the entity map.
   localparam int DEFAULT_SLOTS       = 1024;
   localparam int DEFAULT_MAP_ENTRIES = 1024;

   // Reset value of the usable slot limit and the "no identifier" value.
   localparam logic [CFG_W-1:0] MAX_IDS_RESET = CFG_W'(65536);
   localparam logic [ID_W-1:0]  NO_ID         = '1;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_EXISTING  = 3'd0,
      STATUS_NEW       = 3'd1,
      STATUS_EXHAUSTED = 3'd2,
      STATUS_RELEASED  = 3'd3,
      STATUS_ABSENT    = 3'd4,
      STATUS_MAP_FULL  = 3'd5
   } rsp_status_type;

   // Request operation codes.
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // One request item.
   typedef struct packed {
      logic             operation;
      logic [KEY_W-1:0] entity;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [ID_W-1:0] packed_id;
      rsp_status_type  status;
   } rsp_type;

   // One word of the entity map memory.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  packed_id;
   } map_entry_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_STACK_RD,
      ST_CAND,
      ST_ALLOC,
      ST_GEN_RD,
      ST_RELEASE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           clear;
      logic           start;
      logic           scan;
      logic           stack_read;
      logic           gen_read;
      logic           alloc_commit;
      logic           release_commit;
      logic           respond;
      rsp_status_type rsp_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic hit;
      logic free_found;
      logic op_release;
      logic slot_ok;
   } dp_status_type;

endpackage

/* rtl/gsia_datapath.sv */
// Datapath of the allocator: entity map, generation and free-stack memories, counters.
module gsia_datapath
   import gsia_pkg::*;
#(
   parameter int SLOTS       = DEFAULT_SLOTS,
   parameter int MAP_ENTRIES = DEFAULT_MAP_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_payload,
   input  logic                 csr_write_enable,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output logic                 rsp_valid,
   output rsp_type              rsp_payload
);

   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int MAP_W     = $clog2(MAP_ENTRIES);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int CLEAR_LEN = (SLOTS > MAP_ENTRIES) ? SLOTS : MAP_ENTRIES;
   localparam int CLR_W     = $clog2(CLEAR_LEN);
   localparam int CLR_CMP_W = CLR_W + 1;

   // Memories.
   map_entry_type    map_mem   [MAP_ENTRIES];
   logic [GEN_W-1:0] gen_mem   [SLOTS];
   logic [SLOT_FIELD_W-1:0] stack_mem [SLOTS];

   // Control registers.
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [CFG_W-1:0]  max_ids_ff;
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic [CFG_W-1:0]  next_fresh_ff, next_fresh_in;
   logic [MAP_W-1:0]  scan_addr_ff, scan_addr_in;
   logic              cmp_valid_ff;
   logic              hit_ff, hit_in;
   logic              free_found_ff, free_found_in;
   logic              rsp_valid_ff;

   // Payload registers.
   req_type           req_ff;
   logic [MAP_W-1:0]  cmp_addr_ff;
   logic [MAP_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [ID_W-1:0]   hit_id_ff, hit_id_in;
   logic [MAP_W-1:0]  free_idx_ff, free_idx_in;
   map_entry_type     map_rd_ff;
   logic [GEN_W-1:0]  gen_rd_ff;
   logic [SLOT_FIELD_W-1:0] stack_rd_ff;
   rsp_type           rsp_ff, rsp_in;

   // Combinational signals.
   logic              entry_hit;
   logic              entry_free;
   logic              scan_done;
   logic [ID_W-1:0]   hit_id_now;
   logic              from_stack;
   logic [CFG_W-1:0]  cand;
   logic [CFG_W-1:0]  slot_limit;
   logic              push_ok;
   logic              rel_slot_ok;
   logic [ID_W-1:0]   new_id;
   logic [SLOT_W-1:0] gen_ra;
   logic [SLOT_W-1:0] stack_ra;
   logic              map_we;
   logic [MAP_W-1:0]  map_wa;
   map_entry_type     map_wd;
   logic              gen_we;
   logic [SLOT_W-1:0] gen_wa;
   logic [GEN_W-1:0]  gen_wd;
   logic              clr_map_ok;
   logic              clr_gen_ok;

   // Compare stage of the map scan.
   assign entry_hit  = cmp_valid_ff && map_rd_ff.valid && (map_rd_ff.key == req_ff.entity);
   assign entry_free = cmp_valid_ff && !map_rd_ff.valid;
   assign scan_done  = cmp_valid_ff
                       && (entry_hit || (cmp_addr_ff == MAP_W'(MAP_ENTRIES - 1)));
   assign hit_id_now = entry_hit ? map_rd_ff.packed_id : hit_id_ff;

   // Slot candidate and limit checks.
   assign from_stack  = (free_count_ff != '0);
   assign cand        = from_stack ? {1'b0, stack_rd_ff} : next_fresh_ff;
   assign slot_limit  = (max_ids_ff > CFG_W'(SLOTS)) ? CFG_W'(SLOTS) : max_ids_ff;
   assign push_ok     = (free_count_ff < CNT_W'(SLOTS));
   assign rel_slot_ok = ({1'b0, hit_id_ff[SLOT_FIELD_W-1:0]} < CFG_W'(SLOTS));
   assign new_id      = {gen_rd_ff, cand[SLOT_FIELD_W-1:0]};

   // Memory addresses.
   assign gen_ra   = (req_ff.operation == OP_RELEASE) ? hit_id_ff[SLOT_W-1:0]
                                                      : cand[SLOT_W-1:0];
   assign stack_ra = SLOT_W'(free_count_ff - CNT_W'(1));

   // Clearing pass coverage of each memory.
   assign clr_map_ok = ({1'b0, clr_ff} < CLR_CMP_W'(MAP_ENTRIES));
   assign clr_gen_ok = ({1'b0, clr_ff} < CLR_CMP_W'(SLOTS));

   // Status towards the controller.
   assign status.clear_done = (clr_ff == CLR_W'(CLEAR_LEN - 1));
   assign status.scan_done  = scan_done;
   assign status.hit        = hit_ff || entry_hit;
   assign status.free_found = free_found_ff || entry_free;
   assign status.op_release = (req_ff.operation == OP_RELEASE);
   assign status.slot_ok    = (cand < slot_limit);

   // Map write port: clearing pass, new mapping or invalidation.
   always_comb begin
      map_we = 1'b0;
      map_wa = free_idx_ff;
      map_wd = '{valid: 1'b1, key: req_ff.entity, packed_id: new_id};
      priority if (cmd.clear) begin
         map_we = clr_map_ok;
         map_wa = clr_ff[MAP_W-1:0];
         map_wd = '0;
      end else if (cmd.alloc_commit) begin
         map_we = 1'b1;
      end else if (cmd.release_commit) begin
         map_we = 1'b1;
         map_wa = hit_idx_ff;
         map_wd = '{valid: 1'b0, key: req_ff.entity, packed_id: hit_id_ff};
      end
   end

   // Generation write port: clearing pass or bump on release.
   always_comb begin
      gen_we = 1'b0;
      gen_wa = hit_id_ff[SLOT_W-1:0];
      gen_wd = gen_rd_ff + GEN_W'(1);
      priority if (cmd.clear) begin
         gen_we = clr_gen_ok;
         gen_wa = clr_ff[SLOT_W-1:0];
         gen_wd = '0;
      end else if (cmd.release_commit) begin
         gen_we = rel_slot_ok;
      end
   end

   // Scan bookkeeping and counters.
   always_comb begin
      clr_in        = clr_ff;
      scan_addr_in  = scan_addr_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_id_in     = hit_id_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      free_count_in = free_count_ff;
      next_fresh_in = next_fresh_ff;
      if (cmd.clear && !status.clear_done) begin
         clr_in = clr_ff + CLR_W'(1);
      end
      if (cmd.start) begin
         scan_addr_in  = '0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end
      if (cmd.scan && (scan_addr_ff != MAP_W'(MAP_ENTRIES - 1))) begin
         scan_addr_in = scan_addr_ff + MAP_W'(1);
      end
      if (entry_hit) begin
         hit_in     = 1'b1;
         hit_idx_in = cmp_addr_ff;
         hit_id_in  = map_rd_ff.packed_id;
      end
      if (entry_free && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = cmp_addr_ff;
      end
      if (cmd.alloc_commit) begin
         if (from_stack) begin
            free_count_in = free_count_ff - CNT_W'(1);
         end else begin
            next_fresh_in = next_fresh_ff + CFG_W'(1);
         end
      end
      if (cmd.release_commit && push_ok) begin
         free_count_in = free_count_ff + CNT_W'(1);
      end
   end

   // Result payload by status.
   always_comb begin
      rsp_in.status = cmd.rsp_status;
      unique case (cmd.rsp_status)
         STATUS_EXISTING, STATUS_RELEASED: rsp_in.packed_id = hit_id_now;
         STATUS_NEW:                       rsp_in.packed_id = new_id;
         default:                          rsp_in.packed_id = NO_ID;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         max_ids_ff    <= MAX_IDS_RESET;
         free_count_ff <= '0;
         next_fresh_ff <= '0;
         scan_addr_ff  <= '0;
         cmp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
         scan_addr_ff  <= scan_addr_in;
         cmp_valid_ff  <= cmd.scan && !scan_done;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= cmd.respond;
         if (csr_write_enable) begin
            max_ids_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_payload;
      end
      cmp_addr_ff <= scan_addr_ff;
      hit_idx_ff  <= hit_idx_in;
      hit_id_ff   <= hit_id_in;
      free_idx_ff <= free_idx_in;
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   // Entity map memory.
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      if (cmd.scan) begin
         map_rd_ff <= map_mem[scan_addr_ff];
      end
   end

   // Slot generation memory.
   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_wa] <= gen_wd;
      end
      if (cmd.gen_read) begin
         gen_rd_ff <= gen_mem[gen_ra];
      end
   end

   // Free-slot stack memory.
   always_ff @(posedge clock) begin
      if (cmd.release_commit && push_ok) begin
         stack_mem[free_count_ff[SLOT_W-1:0]] <= hit_id_ff[SLOT_FIELD_W-1:0];
      end
      if (cmd.stack_read) begin
         stack_rd_ff <= stack_mem[stack_ra];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/gsia_ctrl.sv */
// Controller state machine of the allocator.
module gsia_ctrl
   import gsia_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = STATUS_EXISTING;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               if (status.op_release) begin
                  if (status.hit) begin
                     state_in = ST_GEN_RD;
                  end else begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STATUS_ABSENT;
                     state_in       = ST_IDLE;
                  end
               end else begin
                  priority if (status.hit) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STATUS_EXISTING;
                     state_in       = ST_IDLE;
                  end else if (!status.free_found) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STATUS_MAP_FULL;
                     state_in       = ST_IDLE;
                  end else begin
                     state_in = ST_STACK_RD;
                  end
               end
            end
         end
         ST_STACK_RD: begin
            cmd.stack_read = 1'b1;
            state_in       = ST_CAND;
         end
         ST_CAND: begin
            cmd.gen_read = 1'b1;
            if (status.slot_ok) begin
               state_in = ST_ALLOC;
            end else begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = STATUS_EXHAUSTED;
               state_in       = ST_IDLE;
            end
         end
         ST_ALLOC: begin
            cmd.alloc_commit = 1'b1;
            cmd.respond      = 1'b1;
            cmd.rsp_status   = STATUS_NEW;
            state_in         = ST_IDLE;
         end
         ST_GEN_RD: begin
            cmd.gen_read = 1'b1;
            state_in     = ST_RELEASE;
         end
         ST_RELEASE: begin
            cmd.release_commit = 1'b1;
            cmd.respond        = 1'b1;
            cmd.rsp_status     = STATUS_RELEASED;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/generational_slot_id_allocator.sv */
// Top level of the generational slot identifier allocator.
//
// A request (operation, entity) transfers at a rising edge where start is high
// and busy is low. Acquire returns the entity's existing identifier, or maps it
// to a new one built from a recycled or fresh slot and that slot's generation.
// Release frees the entity's mapping, bumps the slot's generation and stacks it.
// Each request gives one result on rsp_payload, marked by rsp_valid for one
// cycle; the receiver cannot stall, so nothing is held back.
// The entity map is walked one entry per cycle through the map memory read port;
// a hit ends the walk. A new mapping then passes the stack read, candidate and
// alloc states, and a release the generation read and release states. busy drops
// in the cycle the result shows, and the next request may transfer in that
// cycle. The map scan sets the throughput.
// After reset, a clearing pass empties the map and zeroes the generations; busy
// is high during it. The csr_ write port sets the usable slot limit at any time,
// including during the pass.
module generational_slot_id_allocator
   import gsia_pkg::*;
#(
   parameter int SLOTS       = DEFAULT_SLOTS,
   parameter int MAP_ENTRIES = DEFAULT_MAP_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   gsia_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Storage and arithmetic.
   gsia_datapath #(
      .SLOTS       (SLOTS),
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

endmodule

/* rtl/gsia_checker.sv */
// Port-level assertions of the allocator and the bind that attaches them.
module gsia_checker
   import gsia_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input rsp_type          rsp_payload
);

   // The clearing pass holds requests off right after reset.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // A transferred request keeps the block busy and gives no result at once.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("request transfer not followed by busy work");

   // Results come one at a time, never in adjacent cycles.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // Failure results carry no identifier.
   a_fail_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == STATUS_EXHAUSTED
                     || rsp_payload.status == STATUS_ABSENT
                     || rsp_payload.status == STATUS_MAP_FULL))
      |-> (rsp_payload.packed_id == NO_ID))
      else $error("failure result with an identifier");

endmodule

bind generational_slot_id_allocator gsia_checker u_gsia_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_payload      (rsp_payload)
);
